[rtl/core/csvt_pkg.sv]
// Shared types and constants of the CSV field tokenizer.
// No dependencies; every other file of the block but csvt_if refers to it by scoped names.
package csvt_pkg;

  // Scan modes of the tokenizer state machine.
  localparam logic [2:0] MODE_LINE   = 3'd0;
  localparam logic [2:0] MODE_FSTART = 3'd1;
  localparam logic [2:0] MODE_PLAIN  = 3'd2;
  localparam logic [2:0] MODE_QUOTED = 3'd3;
  localparam logic [2:0] MODE_QSEEN  = 3'd4;
  localparam logic [2:0] MODE_SKIP   = 3'd5;

  // Token kinds.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;

  // Characters with a meaning to the scanner.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam int unsigned MaxTokens = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

  // The tokens that one input byte produces, first token in slot zero.
  typedef struct packed {
    logic [1:0]           cnt;
    tok_t [MaxTokens-1:0] tok;
  } tok_batch_t;

endpackage

[rtl/core/csvt_if.sv]
// Handshake interfaces of the CSV field tokenizer: raw text in, tokens out.
// Depends on nothing but the valid/ready convention of the project.
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       stream_end;

  modport source (output valid, text_byte, stream_end, input ready);
  modport sink   (input valid, text_byte, stream_end, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] data_byte;
  logic       run_last;

  modport source (output valid, token_kind, data_byte, run_last, input ready);
  modport sink   (input valid, token_kind, data_byte, run_last, output ready);
endinterface

[rtl/core/csv_field_tokenizer.sv]
// Top level of the CSV field tokenizer: mode register, byte decode, token buffer.
// Depends on csvt_pkg, csvt_if, csvt_decode and csvt_tok_queue.
//
// The tokenizer takes CSV text one byte per word on src_i and produces tokens on
// tok_o: a data word for every field byte, an end-of-field word and an
// end-of-record word, with run_last set on the final token a byte causes. Quoted
// fields keep commas and line breaks as data, a doubled quote gives one quote,
// and bytes after a closing quote are dropped up to the next comma or break.
// Blank lines make no records, and a byte flagged stream_end closes any open
// field and record. The scan mode register is updated in the cycle a byte is
// accepted, so a byte may be taken every cycle. Each byte yields zero to three
// tokens, which are loaded into a three-entry buffer that drives tok_o from
// registers, one token per cycle while tok_o is ready; a byte that yields
// several tokens keeps src_i from taking the next byte until the last of them
// leaves, and a stall on tok_o holds src_i too. There is no configuration and
// no start-up sweep; the block is ready right after reset.
module csv_field_tokenizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  csvt_in_if.sink         src_i,
  csvt_out_if.source      tok_o
);

  logic [2:0] mode_q, mode_d;
  logic       record_open_q;
  logic       accept;
  logic       can_load;
  csvt_pkg::tok_batch_t batch;
  csvt_pkg::tok_t       head;

  // The decode sees the current mode and the byte on the input channel.
  csvt_decode u_decode (
    .mode_i       (mode_q),
    .text_byte_i  (src_i.text_byte),
    .stream_end_i (src_i.stream_end),
    .mode_o       (mode_d),
    .batch_o      (batch)
  );

  // Ready only depends on the buffer having room for a whole batch.
  assign src_i.ready = can_load;
  assign accept      = src_i.valid && can_load;

  csvt_tok_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .batch_i     (batch),
    .can_load_o  (can_load),
    .out_valid_o (tok_o.valid),
    .out_ready_i (tok_o.ready),
    .out_tok_o   (head)
  );

  assign tok_o.token_kind = head.kind;
  assign tok_o.data_byte  = head.data;
  assign tok_o.run_last   = head.last;

  // The mode and record flag only move when a byte is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= csvt_pkg::MODE_LINE;
      record_open_q <= 1'b0;
    end else if (accept) begin
      mode_q        <= mode_d;
      record_open_q <= (mode_d != csvt_pkg::MODE_LINE);
    end
  end

  // A record is open exactly when the scanner is away from line start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    record_open_q == (mode_q != csvt_pkg::MODE_LINE))
    else $error("record flag disagrees with scan mode");

  // The unused mode codes are never reached.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= csvt_pkg::MODE_SKIP)
    else $error("scan mode left the defined codes");

  // After the last byte of a stream the scanner is back at line start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && src_i.stream_end) |=> (mode_q == csvt_pkg::MODE_LINE))
    else $error("scanner not at line start after stream end");

  // A new byte is never taken while more than one token is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && !tok_o.run_last) |-> !accept)
    else $error("byte accepted while its predecessor's tokens are pending");

endmodule

[rtl/core/csvt_decode.sv]
// Next-state and token decode for one text byte.
// Uses csvt_pkg for mode codes, token kinds and the token batch type.
module csvt_decode (
  input  logic [2:0]          mode_i,
  input  logic [7:0]          text_byte_i,
  input  logic                stream_end_i,
  output logic [2:0]          mode_o,
  output csvt_pkg::tok_batch_t batch_o
);

  logic       brk;
  logic       is_comma;
  logic       is_quote;
  logic [2:0] m_cur;
  logic [2:0] m_main;
  logic [4:0] emit;
  logic       open_field;
  csvt_pkg::tok_t [4:0] cand;
  csvt_pkg::tok_t [csvt_pkg::MaxTokens-1:0] toks;
  logic [2:0] n;

  assign brk      = (text_byte_i == csvt_pkg::CH_CR) || (text_byte_i == csvt_pkg::CH_LF);
  assign is_comma = (text_byte_i == csvt_pkg::CH_COMMA);
  assign is_quote = (text_byte_i == csvt_pkg::CH_QUOTE);
  // Unused codes behave as line start.
  assign m_cur    = (mode_i > csvt_pkg::MODE_SKIP) ? csvt_pkg::MODE_LINE : mode_i;

  // emit[0] data, emit[1] field end, emit[2] record end,
  // emit[3] field end at stream end, emit[4] record end at stream end.
  always_comb begin
    m_main   = m_cur;
    emit     = '0;
    case (m_cur)
      csvt_pkg::MODE_LINE, csvt_pkg::MODE_FSTART: begin
        if (brk) begin
          emit[2] = (m_cur == csvt_pkg::MODE_FSTART);
          m_main  = csvt_pkg::MODE_LINE;
        end else if (is_comma) begin
          emit[1] = 1'b1;
          m_main  = csvt_pkg::MODE_FSTART;
        end else if (is_quote) begin
          m_main  = csvt_pkg::MODE_QUOTED;
        end else begin
          emit[0] = 1'b1;
          m_main  = csvt_pkg::MODE_PLAIN;
        end
      end
      csvt_pkg::MODE_QUOTED: begin
        if (is_quote) begin
          m_main  = csvt_pkg::MODE_QSEEN;
        end else begin
          emit[0] = 1'b1;
        end
      end
      default: begin
        // Plain field, skip after closing quote, or quote seen in a quoted field.
        if (m_cur == csvt_pkg::MODE_QSEEN && is_quote) begin
          emit[0] = 1'b1;
          m_main  = csvt_pkg::MODE_QUOTED;
        end else if (is_comma) begin
          emit[1] = 1'b1;
          m_main  = csvt_pkg::MODE_FSTART;
        end else if (brk) begin
          emit[1] = 1'b1;
          emit[2] = 1'b1;
          m_main  = csvt_pkg::MODE_LINE;
        end else if (m_cur == csvt_pkg::MODE_QSEEN) begin
          m_main  = csvt_pkg::MODE_SKIP;
        end else if (m_cur == csvt_pkg::MODE_PLAIN) begin
          emit[0] = 1'b1;
        end
      end
    endcase

    open_field = (m_main == csvt_pkg::MODE_PLAIN) || (m_main == csvt_pkg::MODE_QUOTED) ||
                 (m_main == csvt_pkg::MODE_QSEEN) || (m_main == csvt_pkg::MODE_SKIP);
    if (stream_end_i) begin
      emit[3] = open_field;
      emit[4] = open_field || (m_main == csvt_pkg::MODE_FSTART);
      mode_o  = csvt_pkg::MODE_LINE;
    end else begin
      mode_o  = m_main;
    end
  end

  always_comb begin
    cand[0] = '{kind: csvt_pkg::KIND_DATA,   data: text_byte_i, last: 1'b0};
    cand[1] = '{kind: csvt_pkg::KIND_FIELD,  data: 8'h00,       last: 1'b0};
    cand[2] = '{kind: csvt_pkg::KIND_RECORD, data: 8'h00,       last: 1'b0};
    cand[3] = '{kind: csvt_pkg::KIND_FIELD,  data: 8'h00,       last: 1'b0};
    cand[4] = '{kind: csvt_pkg::KIND_RECORD, data: 8'h00,       last: 1'b0};
    toks    = '0;
    n       = 3'd0;
    // Pack the raised candidates into the low slots, keeping their order.
    for (int i = 0; i < 5; i++) begin
      if (emit[i]) begin
        if (n < 3'(csvt_pkg::MaxTokens)) begin
          toks[n[1:0]] = cand[i];
        end
        n = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      toks[2'(n - 3'd1)].last = 1'b1;
    end
    batch_o.cnt = n[1:0];
    batch_o.tok = toks;
  end

endmodule

[rtl/core/csvt_tok_queue.sv]
// Three-slot token buffer that hands out one token per handshake.
// Uses csvt_pkg for the token and batch types.
module csvt_tok_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  csvt_pkg::tok_batch_t batch_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output csvt_pkg::tok_t       out_tok_o
);

  logic [1:0] cnt_q, cnt_d;
  csvt_pkg::tok_t [csvt_pkg::MaxTokens-1:0] slot_q, slot_d;
  logic pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_tok_o   = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // A new batch may come in when the buffer is empty or its last token leaves this cycle.
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (load_i) begin
      cnt_d  = batch_i.cnt;
      slot_d = batch_i.tok;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[dv/csv_field_tokenizer_tb.sv]
// Self-checking testbench of the CSV field tokenizer: directed rows, then random CSV records.
// Depends on csvt_pkg, csvt_if and the csv_field_tokenizer RTL.
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;

  // The run length is bounded by a cycle count. A clean run stays far below this limit.
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned RandomItems  = 250;
  localparam int unsigned DirRows      = 27;
  localparam int unsigned DrainCycles  = 100;

  // One row of the directed table. Where typed is set, want holds the tokens that the
  // row must produce. Other rows are checked against the predictor.
  typedef struct packed {
    logic [7:0]           text;
    logic                 fin;
    logic                 typed;
    csvt_pkg::tok_batch_t want;
  } row_t;

  localparam csvt_pkg::tok_t NoTok = '0;

  logic clk = 1'b0;
  logic rst_n;

  csvt_in_if  src_if ();
  csvt_out_if tok_if ();

  csv_field_tokenizer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .src_i  (src_if),
    .tok_o  (tok_if)
  );

  // The clock runs with a period of 4 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the scanner state. Reset is applied once, so the initial values stand for it.
  logic [2:0] scan_mode = csvt_pkg::MODE_LINE;
  logic       in_record = 1'b0;

  // Tokens that the accepted bytes have caused and that have not yet come out, oldest first.
  csvt_pkg::tok_t expected_tokens[$];
  // Bytes of the random record being sent, with stream_end in bit 8.
  logic [8:0] text_q[$];
  row_t dir_rows [DirRows];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit steady_src = 1'b0;
  bit steady_snk = 1'b0;

  // Adds a token at the tail of the expectation list.
  function automatic void expect_tok(input csvt_pkg::tok_t t);
    expected_tokens = {expected_tokens, t};
  endfunction

  // Adds a byte at the tail of the record being built.
  function automatic void append_text(input logic [8:0] w);
    text_q = {text_q, w};
  endfunction

  function automatic csvt_pkg::tok_t tk(input logic [1:0] kind, input int data);
    return '{kind: kind, data: 8'(data), last: 1'b0};
  endfunction

  function automatic row_t mk_row(input logic [7:0] text, input int fin, input int typed,
                                  input int cnt, input csvt_pkg::tok_t a,
                                  input csvt_pkg::tok_t b, input csvt_pkg::tok_t c);
    row_t r;
    r.text = text;
    r.fin = 1'(fin);
    r.typed = 1'(typed);
    r.want.cnt = 2'(cnt);
    r.want.tok[0] = a;
    r.want.tok[1] = b;
    r.want.tok[2] = c;
    if (cnt > 0) r.want.tok[2'(cnt - 1)].last = 1'b1;
    return r;
  endfunction

  // Appends one token to a batch. Only data tokens carry a byte.
  function automatic void add_tok(inout csvt_pkg::tok_batch_t bt, input logic [1:0] kind,
                                  input logic [7:0] b);
    bt.tok[bt.cnt] = '{kind: kind, data: (kind == csvt_pkg::KIND_DATA) ? b : 8'h00,
                       last: 1'b0};
    bt.cnt = bt.cnt + 2'd1;
  endfunction

  // Works out the tokens that one byte produces and advances the mirrored scanner state.
  function automatic csvt_pkg::tok_batch_t tokenize_byte(input logic [7:0] b, input logic fin);
    csvt_pkg::tok_batch_t bt;
    logic [2:0] m;
    logic       brk;
    logic       closing;
    bt = '0;
    closing = 1'b0;
    // The unused mode codes behave as line start.
    m = (scan_mode > csvt_pkg::MODE_SKIP) ? csvt_pkg::MODE_LINE : scan_mode;
    brk = (b == csvt_pkg::CH_CR) || (b == csvt_pkg::CH_LF);
    case (m)
      csvt_pkg::MODE_LINE, csvt_pkg::MODE_FSTART: begin
        if (brk) begin
          // A break right after a comma closes the record with no empty field;
          // a break at line start is a blank line and makes nothing.
          if (m == csvt_pkg::MODE_FSTART) add_tok(bt, csvt_pkg::KIND_RECORD, 8'h00);
          m = csvt_pkg::MODE_LINE;
        end else if (b == csvt_pkg::CH_COMMA) begin
          add_tok(bt, csvt_pkg::KIND_FIELD, 8'h00);
          m = csvt_pkg::MODE_FSTART;
        end else if (b == csvt_pkg::CH_QUOTE) begin
          m = csvt_pkg::MODE_QUOTED;
        end else begin
          add_tok(bt, csvt_pkg::KIND_DATA, b);
          m = csvt_pkg::MODE_PLAIN;
        end
      end
      csvt_pkg::MODE_QUOTED: begin
        if (b == csvt_pkg::CH_QUOTE) m = csvt_pkg::MODE_QSEEN;
        else add_tok(bt, csvt_pkg::KIND_DATA, b);
      end
      csvt_pkg::MODE_QSEEN: begin
        if (b == csvt_pkg::CH_QUOTE) begin
          // A doubled quote is one literal quote.
          add_tok(bt, csvt_pkg::KIND_DATA, b);
          m = csvt_pkg::MODE_QUOTED;
        end else if (b != csvt_pkg::CH_COMMA && !brk) begin
          m = csvt_pkg::MODE_SKIP;
        end else begin
          closing = 1'b1;
        end
      end
      default: closing = 1'b1;
    endcase
    if (closing) begin
      if (b == csvt_pkg::CH_COMMA) begin
        add_tok(bt, csvt_pkg::KIND_FIELD, 8'h00);
        m = csvt_pkg::MODE_FSTART;
      end else if (brk) begin
        add_tok(bt, csvt_pkg::KIND_FIELD, 8'h00);
        add_tok(bt, csvt_pkg::KIND_RECORD, 8'h00);
        m = csvt_pkg::MODE_LINE;
      end else if (m == csvt_pkg::MODE_PLAIN) begin
        add_tok(bt, csvt_pkg::KIND_DATA, b);
      end
    end
    if (fin) begin
      // The end of the stream closes an open field and record.
      if (m inside {csvt_pkg::MODE_PLAIN, csvt_pkg::MODE_QUOTED, csvt_pkg::MODE_QSEEN,
                    csvt_pkg::MODE_SKIP}) begin
        add_tok(bt, csvt_pkg::KIND_FIELD, 8'h00);
        add_tok(bt, csvt_pkg::KIND_RECORD, 8'h00);
      end else if (m == csvt_pkg::MODE_FSTART) begin
        add_tok(bt, csvt_pkg::KIND_RECORD, 8'h00);
      end
      m = csvt_pkg::MODE_LINE;
    end
    scan_mode = m;
    in_record = (m != csvt_pkg::MODE_LINE);
    if (bt.cnt != 2'd0) bt.tok[bt.cnt - 2'd1].last = 1'b1;
    return bt;
  endfunction

  // Length of a pause on either side: mostly none or short, now and then long.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A byte with a bias toward the characters that steer the scanner.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return csvt_pkg::CH_QUOTE;
      1: return csvt_pkg::CH_COMMA;
      2: return csvt_pkg::CH_CR;
      3: return csvt_pkg::CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A byte that an unquoted field may hold.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b inside {csvt_pkg::CH_QUOTE, csvt_pkg::CH_COMMA, csvt_pkg::CH_CR,
                     csvt_pkg::CH_LF});
    return b;
  endfunction

  // Offers one byte after an optional gap and waits for the block to take it. The
  // expected tokens are queued at the edge where the word is accepted. Typed rows
  // still run through the predictor so that its state follows the stream.
  task automatic feed_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input csvt_pkg::tok_batch_t given);
    int gap;
    csvt_pkg::tok_batch_t pred;
    gap = steady_src ? 0 : pause_len();
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_if.valid      <= 1'b1;
    src_if.text_byte  <= b;
    src_if.stream_end <= fin;
    do @(posedge clk);
    while (!src_if.ready);
    pred = tokenize_byte(b, fin);
    if (typed) pred = given;
    for (int i = 0; i < pred.cnt; i++) expect_tok(pred.tok[i]);
  endtask

  // Token side: every accepted word is checked against the oldest expectation, then
  // ready is decided for the next cycle. Stalls come in runs, with steady stretches.
  initial begin
    int stall_left;
    csvt_pkg::tok_t exp_tok;
    stall_left = 0;
    tok_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (tok_if.valid && tok_if.ready) begin
        if (expected_tokens.size() == 0) begin
          errors++;
          $error("token with none expected: kind %0d data %02h last %0b",
                 tok_if.token_kind, tok_if.data_byte, tok_if.run_last);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (tok_if.token_kind !== exp_tok.kind) begin
            errors++;
            $error("token_kind: expected %0d, actual %0d", exp_tok.kind, tok_if.token_kind);
          end
          if (tok_if.data_byte !== exp_tok.data) begin
            errors++;
            $error("data_byte: expected %02h, actual %02h", exp_tok.data, tok_if.data_byte);
          end
          if (tok_if.run_last !== exp_tok.last) begin
            errors++;
            $error("run_last: expected %0b, actual %0b", exp_tok.last, tok_if.run_last);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) steady_snk = !steady_snk;
      if (stall_left == 0 && !steady_snk) stall_left = pause_len();
      if (stall_left > 0) begin
        tok_if.ready <= 1'b0;
        stall_left--;
      end else begin
        tok_if.ready <= 1'b1;
      end
    end
  end

  // A hung block must not hold the run forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("csv_field_tokenizer_tb: errors");
      $finish;
    end
  end

  // Reset, the directed table, the random records, and the final verdict.
  initial begin
    int unsigned fed;
    int nfields;
    int cut;
    int r;
    logic [7:0] c;

    rst_n             <= 1'b0;
    src_if.valid      <= 1'b0;
    src_if.text_byte  <= 8'h00;
    src_if.stream_end <= 1'b0;

    // Directed part. It starts right after reset at line start.
    dir_rows[0]  = mk_row("a",      0, 1, 1, tk(csvt_pkg::KIND_DATA, "a"), NoTok, NoTok);
    dir_rows[1]  = mk_row(csvt_pkg::CH_COMMA, 0, 1, 1, tk(csvt_pkg::KIND_FIELD, 0),
                          NoTok, NoTok);
    // Two commas in a row give an empty field.
    dir_rows[2]  = mk_row(csvt_pkg::CH_COMMA, 0, 1, 1, tk(csvt_pkg::KIND_FIELD, 0),
                          NoTok, NoTok);
    // A break right after a comma ends the record without another field.
    dir_rows[3]  = mk_row(csvt_pkg::CH_LF,    0, 1, 1, tk(csvt_pkg::KIND_RECORD, 0),
                          NoTok, NoTok);
    // Blank lines make no records.
    dir_rows[4]  = mk_row(csvt_pkg::CH_CR,    0, 1, 0, NoTok, NoTok, NoTok);
    dir_rows[5]  = mk_row(csvt_pkg::CH_LF,    0, 1, 0, NoTok, NoTok, NoTok);
    // A comma at line start opens a record with an empty first field.
    dir_rows[6]  = mk_row(csvt_pkg::CH_COMMA, 0, 1, 1, tk(csvt_pkg::KIND_FIELD, 0),
                          NoTok, NoTok);
    dir_rows[7]  = mk_row(csvt_pkg::CH_QUOTE, 0, 1, 0, NoTok, NoTok, NoTok);
    dir_rows[8]  = mk_row(8'h00,    0, 1, 1, tk(csvt_pkg::KIND_DATA, 8'h00), NoTok, NoTok);
    dir_rows[9]  = mk_row(8'hFF,    0, 1, 1, tk(csvt_pkg::KIND_DATA, 8'hFF), NoTok, NoTok);
    // Breaks, commas and doubled quotes inside a quoted field are data.
    dir_rows[10] = mk_row(csvt_pkg::CH_CR,    0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[11] = mk_row(csvt_pkg::CH_COMMA, 0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[12] = mk_row(csvt_pkg::CH_QUOTE, 0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[13] = mk_row(csvt_pkg::CH_QUOTE, 0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[14] = mk_row(csvt_pkg::CH_QUOTE, 0, 0, 0, NoTok, NoTok, NoTok);
    // Bytes after the closing quote are dropped up to the next separator.
    dir_rows[15] = mk_row("x",      0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[16] = mk_row("y",      0, 1, 0, NoTok, NoTok, NoTok);
    dir_rows[17] = mk_row(csvt_pkg::CH_CR,    0, 1, 2, tk(csvt_pkg::KIND_FIELD, 0),
                          tk(csvt_pkg::KIND_RECORD, 0), NoTok);
    // An empty quoted field followed by a comma, then a plain field.
    dir_rows[18] = mk_row(csvt_pkg::CH_QUOTE, 0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[19] = mk_row(csvt_pkg::CH_QUOTE, 0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[20] = mk_row(csvt_pkg::CH_COMMA, 0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[21] = mk_row("b",      0, 0, 0, NoTok, NoTok, NoTok);
    dir_rows[22] = mk_row(csvt_pkg::CH_LF,    0, 1, 2, tk(csvt_pkg::KIND_FIELD, 0),
                          tk(csvt_pkg::KIND_RECORD, 0), NoTok);
    // Stream end in a plain field, right after a comma, at line start, in a quoted field.
    dir_rows[23] = mk_row("c",      1, 1, 3, tk(csvt_pkg::KIND_DATA, "c"),
                          tk(csvt_pkg::KIND_FIELD, 0), tk(csvt_pkg::KIND_RECORD, 0));
    dir_rows[24] = mk_row(csvt_pkg::CH_COMMA, 1, 1, 2, tk(csvt_pkg::KIND_FIELD, 0),
                          tk(csvt_pkg::KIND_RECORD, 0), NoTok);
    dir_rows[25] = mk_row(csvt_pkg::CH_LF,    1, 1, 0, NoTok, NoTok, NoTok);
    dir_rows[26] = mk_row(csvt_pkg::CH_QUOTE, 1, 1, 2, tk(csvt_pkg::KIND_FIELD, 0),
                          tk(csvt_pkg::KIND_RECORD, 0), NoTok);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      feed_byte(dir_rows[i].text, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part. Most words form well-built records with random content; the rest
    // is noise. Some records are cut short by a stream end.
    fed = 0;
    while (fed < RandomItems) begin
      text_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) append_text({1'b0, noise_byte()});
      end else begin
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
          if (f > 0) append_text({1'b0, csvt_pkg::CH_COMMA});
          case ($urandom_range(0, 3))
            0: ;
            1, 2: repeat ($urandom_range(1, 5)) append_text({1'b0, plain_byte()});
            default: begin
              append_text({1'b0, csvt_pkg::CH_QUOTE});
              repeat ($urandom_range(0, 5)) begin
                c = noise_byte();
                append_text({1'b0, c});
                if (c == csvt_pkg::CH_QUOTE) append_text({1'b0, csvt_pkg::CH_QUOTE});
              end
              append_text({1'b0, csvt_pkg::CH_QUOTE});
              if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 2)) append_text({1'b0, plain_byte()});
              end
            end
          endcase
        end
        if ($urandom_range(0, 7) == 0) append_text({1'b0, csvt_pkg::CH_COMMA});
        case ($urandom_range(0, 3))
          0: append_text({1'b0, csvt_pkg::CH_CR});
          1: append_text({1'b0, csvt_pkg::CH_LF});
          2: begin
            append_text({1'b0, csvt_pkg::CH_CR});
            append_text({1'b0, csvt_pkg::CH_LF});
          end
          default: begin
            append_text({1'b0, csvt_pkg::CH_CR});
            append_text({1'b0, csvt_pkg::CH_LF});
            append_text({1'b0, csvt_pkg::CH_LF});
          end
        endcase
      end
      r = $urandom_range(0, 9);
      if (r <= 1) begin
        cut = (r == 0) ? $urandom_range(0, text_q.size() - 1) : text_q.size() - 1;
        text_q = text_q[0:cut];
        text_q[cut] = {1'b1, text_q[cut][7:0]};
      end
      if ($urandom_range(0, 15) == 0) steady_src = !steady_src;
      foreach (text_q[i]) feed_byte(text_q[i][7:0], text_q[i][8], 1'b0, '0);
      fed += text_q.size();
    end
    src_if.valid <= 1'b0;

    // Let the buffer drain, then watch a while longer for stray words.
    wait (expected_tokens.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("csv_field_tokenizer_tb: clean");
    end else begin
      $display("csv_field_tokenizer_tb: errors");
    end
    $finish;
  end

endmodule
